>>> design/u2a_pkg.sv
// Shared types and constants for the unsigned-to-ASCII digit converter.
// Holds the beat structs, controller/datapath signals and the decimal threshold table.
// No dependencies.
`default_nettype none

package u2a_pkg;

   // Digit positions: decimal runs 9 down to 0, hexadecimal 7 down to 0.
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] DEC_TOP_POS = 4'd9;
   localparam logic [POS_W-1:0] HEX_TOP_POS = 4'd7;
   localparam int unsigned DEC_BASE = 10;
   localparam int unsigned DEC_DIGITS = 10;
   localparam logic [6:0] CHAR_ZERO = 7'd48;
   localparam logic [6:0] CHAR_LOWER_A = 7'd97;
   localparam int unsigned THR_W = 36;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [6:0] digit_char;
      logic       last_digit;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } u2a_cmd_type;

   typedef struct packed {
      logic digit_zero;
      logic pos_zero;
   } u2a_sts_type;

   // Row p, column k holds k * 10^p, wide enough for 9 * 10^9; column zero is zero.
   typedef logic [9:0][THR_W-1:0] thr_row_type;
   typedef thr_row_type [DEC_DIGITS-1:0] thr_table_type;

   function automatic thr_table_type build_thr();
      thr_table_type    t;
      logic [THR_W-1:0] pw;
      t  = '0;
      pw = THR_W'(1);
      for (int p = 0; p < DEC_DIGITS; p++) begin
         for (int k = 0; k <= 9; k++) begin
            t[p][k] = THR_W'(pw * THR_W'(k));
         end
         pw = THR_W'(pw * THR_W'(DEC_BASE));
      end
      return t;
   endfunction

   localparam thr_table_type DEC_THR = build_thr();

endpackage

`default_nettype wire

>>> design/u2a_ctrl.sv
// Controller state machine for the digit converter.
// Depends on u2a_pkg for the command and status structs.
`default_nettype none

module u2a_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire u2a_pkg::u2a_sts_type sts,
   output u2a_pkg::u2a_cmd_type      cmd
);
   import u2a_pkg::*;

   typedef enum logic {
      IDLE,
      CONV
   } state_type;

   state_type state_ff, state_in;
   logic      seen_ff, seen_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_step;

   // The datapath may advance when the output register is empty or being drained.
   assign can_step  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next-state logic: leading zeros are skipped except at position zero; other digits are emitted.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               seen_in  = 1'b0;
               state_in = CONV;
            end
         end
         CONV: begin
            if (can_step) begin
               cmd.step = 1'b1;
               if (!(sts.digit_zero && !seen_ff && !sts.pos_zero)) begin
                  cmd.emit     = 1'b1;
                  rsp_valid_in = 1'b1;
                  seen_in      = 1'b1;
                  if (sts.pos_zero) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> design/u2a_datapath.sv
// Datapath for the digit converter: remainder, position and output register.
// Depends on u2a_pkg for the beat structs and the decimal threshold table.
`default_nettype none

module u2a_datapath (
   input  wire logic                 clock,
   input  wire u2a_pkg::req_type     req_data,
   input  wire u2a_pkg::u2a_cmd_type cmd,
   output u2a_pkg::u2a_sts_type      sts,
   output u2a_pkg::rsp_type          rsp_data
);
   import u2a_pkg::*;

   logic [31:0]      rem_ff, rem_in;
   logic [POS_W-1:0] pos_ff;
   logic             hex_ff;
   rsp_type          rsp_ff;
   logic [8:0]       ge;
   logic [3:0]       dec_digit;
   logic [3:0]       digit;
   logic [THR_W-1:0] sub;
   logic [6:0]       digit_char;

   // Decimal digit: count the multiples of 10^pos that fit into the remainder.
   always_comb begin
      dec_digit = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         ge[k-1]   = ({{(THR_W-32){1'b0}}, rem_ff} >= DEC_THR[pos_ff][k]);
         dec_digit = dec_digit + {3'b000, ge[k-1]};
      end
      sub = DEC_THR[pos_ff][dec_digit];
   end

   // Select the digit and the remainder that follows it.
   always_comb begin
      if (hex_ff) begin
         digit  = rem_ff[31:28];
         rem_in = {rem_ff[27:0], 4'b0000};
      end else begin
         digit  = dec_digit;
         rem_in = rem_ff - sub[31:0];
      end
      if (digit < 4'd10) begin
         digit_char = CHAR_ZERO + {3'b000, digit};
      end else begin
         digit_char = CHAR_LOWER_A + {3'b000, digit} - 7'd10;
      end
   end

   assign sts.digit_zero = (digit == 4'd0);
   assign sts.pos_zero   = (pos_ff == '0);
   assign rsp_data       = rsp_ff;

   // Working registers and the output beat register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= req_data.value;
         hex_ff <= req_data.kind;
         pos_ff <= req_data.kind ? HEX_TOP_POS : DEC_TOP_POS;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         pos_ff <= pos_ff - 1'b1;
      end
      if (cmd.emit) begin
         rsp_ff.digit_char <= digit_char;
         rsp_ff.last_digit <= sts.pos_zero;
      end
   end

endmodule

`default_nettype wire

>>> design/uint_to_ascii_digits.sv
// Top level of the unsigned-to-ASCII digit converter.
// Depends on u2a_pkg, u2a_ctrl and u2a_datapath.
//
//   Channel | Direction | Beat contents
//   req     | in        | kind (0 decimal, 1 hex), value[31:0]
//   rsp     | out       | digit_char[6:0], last_digit
//
// A value is loaded first, then the loop visits every digit position: ten for decimal,
// eight for hexadecimal.
// The digit loop steps through positions one per cycle while no rsp beat is stalled, leading zeros included.
// Reset is synchronous and active high; it empties the output register.
// A stalled rsp beat holds the loop; a new value is taken while the last digit waits.
`default_nettype none

module uint_to_ascii_digits (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire u2a_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output u2a_pkg::rsp_type      rsp_data
);
   import u2a_pkg::*;

   u2a_cmd_type cmd;
   u2a_sts_type sts;

   // Sequencing of load, step and emit.
   u2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Digit extraction and output register.
   u2a_datapath u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/u2a_checker.sv
// Port-level checks for the digit converter, bound to its top level.
// Depends on u2a_pkg for the beat structs.
`default_nettype none

module u2a_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire u2a_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire u2a_pkg::rsp_type rsp_data
);
   import u2a_pkg::*;

   // A waiting request beat holds its contents until taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req beat changed while waiting");

   // A stalled result beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // Once a value is taken the block is busy converting it.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted again straight after an accept");

   // A beat still waiting while the block is idle must close a run.
   a_idle_pending_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_data.last_digit)
      else $error("idle with a digit pending that is not the last");

   // Every digit is a decimal or lower-case hexadecimal character.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.digit_char >= 7'd48 && rsp_data.digit_char <= 7'd57)
                 || (rsp_data.digit_char >= 7'd97 && rsp_data.digit_char <= 7'd102))
      else $error("digit character out of range");

endmodule

bind uint_to_ascii_digits u2a_checker u_u2a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
